/* hdl/pdf_pkg.sv */
// Shared types and constants for the PDM decimating FIR core.
// Field widths, request codes and the MAC control struct; no dependencies.
`timescale 1ns / 1ps

package pdf_pkg;

  localparam int SAMPLE_W = 16;
  localparam int COEF_W   = 16;
  localparam int PCM_W    = 38;
  localparam int DEC_W    = 7;
  localparam int PHASE_W  = 6;

  localparam logic [DEC_W-1:0] DEC_MAX   = 7'd64;
  localparam logic [DEC_W-1:0] DEC_RESET = 7'd8;

  // Request kinds carried in the input tuser
  localparam logic REQ_SAMPLE = 1'b0;
  localparam logic REQ_COEF   = 1'b1;

  // Control that travels with each multiply-accumulate operand pair
  typedef struct packed {
    logic valid;
    logic first;
    logic last;
  } mac_ctl_t;

endpackage

/* hdl/pdf_mac.sv */
// Multiply-accumulate datapath: registered 16x16 product, then a 38-bit wrapping sum.
// Depends on pdf_pkg for widths and the mac_ctl_t control struct.
`timescale 1ns / 1ps

module pdf_mac (
  input  logic                                clk,
  input  logic                                rst,
  input  pdf_pkg::mac_ctl_t                   ctl,
  input  logic signed [pdf_pkg::SAMPLE_W-1:0] smp,
  input  logic signed [pdf_pkg::COEF_W-1:0]   coef,
  output logic                                done,
  output logic signed [pdf_pkg::PCM_W-1:0]    sum
);

  localparam int PROD_W = pdf_pkg::SAMPLE_W + pdf_pkg::COEF_W;

  pdf_pkg::mac_ctl_t        ctl_p;
  logic signed [PROD_W-1:0] prod;

  // Register the product and its control
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_p <= '0;
    end else begin
      ctl_p <= ctl;
    end
    prod <= smp * coef;
  end

  // Accumulate; the first term restarts the sum
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= ctl_p.valid && ctl_p.last;
    end
    if (ctl_p.valid) begin
      if (ctl_p.first) begin
        sum <= pdf_pkg::PCM_W'(prod);
      end else begin
        sum <= sum + pdf_pkg::PCM_W'(prod);
      end
    end
  end

endmodule

/* hdl/pdm_decimating_fir_core.sv */
// A sample beat that completes a decimation period starts a walk over all TAPS taps; reads,
//   product and sum are registered, and m_axis_tvalid rises once the previous output beat is taken.
// The core holds s_axis_tready low from that acceptance until the beat is handed over; other
//   sample beats and coefficient writes leave it idle and ready.
// Reset (rst, synchronous): clears fill and phase counts, write pointers, decimation to 8;
//   window and coefficient memories are not cleared.
`timescale 1ns / 1ps

module pdm_decimating_fir_core #(
  parameter int CHANNELS = 4,
  parameter int TAPS     = 64
) (
  input  logic                       clk,
  input  logic                       rst,
  // Configuration: decimation register
  input  logic                       cfg_we,
  input  logic [pdf_pkg::DEC_W-1:0]  cfg_wdata,
  // Input stream
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  input  logic [39:0]                s_axis_tdata,  // sample[15:0], coef_index[21:16],
                                                    // coef_value[37:22], zero pad
  input  logic [2:0]                 s_axis_tuser,  // req_type[0], channel[2:1]
  // Output stream
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  output logic [39:0]                m_axis_tdata,  // pcm_value[37:0], zero pad
  output logic [1:0]                 m_axis_tuser   // out_channel[1:0]
);

  localparam int CH_W      = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int TAP_W     = $clog2(TAPS);
  localparam int IW        = TAP_W + 1;
  localparam int FILL_W    = $clog2(TAPS + 1);
  localparam int WIN_DEPTH = CHANNELS * TAPS;
  localparam int WIN_AW    = $clog2(WIN_DEPTH);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_WAIT = 2'd2;
  localparam logic [1:0] ST_HOLD = 2'd3;

  // Input fields
  logic                                req_type;
  logic [1:0]                          channel;
  logic signed [pdf_pkg::SAMPLE_W-1:0] sample;
  logic [5:0]                          coef_index;
  logic signed [pdf_pkg::COEF_W-1:0]   coef_value;

  assign req_type   = s_axis_tuser[0];
  assign channel    = s_axis_tuser[2:1];
  assign sample     = s_axis_tdata[15:0];
  assign coef_index = s_axis_tdata[21:16];
  assign coef_value = s_axis_tdata[37:22];

  // Control state
  logic [1:0]                  state;
  logic [pdf_pkg::DEC_W-1:0]   decimation;
  logic [FILL_W-1:0]           fill_count [CHANNELS];
  logic [pdf_pkg::PHASE_W-1:0] phase_count [CHANNELS];
  logic [TAP_W-1:0]            wptr [CHANNELS];
  logic [CH_W-1:0]             rd_ch;
  logic [TAP_W-1:0]            rd_base;
  logic [TAP_W-1:0]            rd_k;

  // Memories
  logic signed [pdf_pkg::SAMPLE_W-1:0] win_mem [WIN_DEPTH];
  logic signed [pdf_pkg::COEF_W-1:0]   coef_mem [TAPS];
  logic signed [pdf_pkg::SAMPLE_W-1:0] win_rd;
  logic signed [pdf_pkg::COEF_W-1:0]   coef_rd;

  pdf_pkg::mac_ctl_t issue;
  pdf_pkg::mac_ctl_t issue_q;
  logic              mac_done;
  logic signed [pdf_pkg::PCM_W-1:0] mac_sum;

  logic                        accept;
  logic                        smp_ok;
  logic                        coef_ok;
  logic [CH_W-1:0]             ch_idx;
  logic [FILL_W-1:0]           fill_cur;
  logic [pdf_pkg::PHASE_W-1:0] phase_cur;
  logic [pdf_pkg::DEC_W-1:0]   phase_inc;
  logic [pdf_pkg::DEC_W-1:0]   dec_eff;
  logic                        emit;
  logic [FILL_W-1:0]           fill_next;
  logic [pdf_pkg::PHASE_W-1:0] phase_next;
  logic [TAP_W-1:0]            wptr_cur;
  logic [TAP_W-1:0]            wptr_next;
  logic [WIN_AW-1:0]           wr_addr;
  logic [IW-1:0]               wrap_idx;
  logic [TAP_W-1:0]            tap_idx;
  logic [WIN_AW-1:0]           rd_addr;
  logic                        out_free;

  assign s_axis_tready = (state == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign smp_ok        = (req_type == pdf_pkg::REQ_SAMPLE) && (32'(channel) < CHANNELS);
  assign coef_ok       = (req_type == pdf_pkg::REQ_COEF) && (32'(coef_index) < TAPS);
  assign ch_idx        = CH_W'(channel);
  assign out_free      = !m_axis_tvalid || m_axis_tready;

  // Effective decimation: zero acts as one, large values clamp
  always_comb begin
    if (decimation == '0) begin
      dec_eff = pdf_pkg::DEC_W'(1);
    end else if (decimation > pdf_pkg::DEC_MAX) begin
      dec_eff = pdf_pkg::DEC_MAX;
    end else begin
      dec_eff = decimation;
    end
  end

  // Decide whether this sample closes a decimation period
  always_comb begin
    fill_cur   = fill_count[ch_idx];
    phase_cur  = phase_count[ch_idx];
    phase_inc  = {1'b0, phase_cur} + pdf_pkg::DEC_W'(1);
    fill_next  = fill_cur;
    phase_next = phase_cur;
    emit       = 1'b0;
    if (32'(fill_cur) < TAPS) begin
      fill_next = fill_cur + FILL_W'(1);
      if (32'(fill_next) == TAPS) begin
        emit       = 1'b1;
        phase_next = '0;
      end
    end else if (phase_inc >= dec_eff) begin
      emit       = 1'b1;
      phase_next = '0;
    end else begin
      phase_next = phase_inc[pdf_pkg::PHASE_W-1:0];
    end
  end

  // Ring write pointer of the addressed channel
  assign wptr_cur  = wptr[ch_idx];
  assign wptr_next = (32'(wptr_cur) == TAPS - 1) ? '0 : wptr_cur + TAP_W'(1);
  assign wr_addr   = WIN_AW'(32'(ch_idx) * TAPS + 32'(wptr_cur));

  // Tap k sits k places behind the newest sample, modulo TAPS
  assign wrap_idx = {1'b0, rd_base} + IW'(TAPS) - {1'b0, rd_k};
  assign tap_idx  = (rd_base >= rd_k) ? (rd_base - rd_k) : wrap_idx[TAP_W-1:0];
  assign rd_addr  = WIN_AW'(32'(rd_ch) * TAPS + 32'(tap_idx));

  always_comb begin
    issue.valid = (state == ST_RUN);
    issue.first = (rd_k == '0);
    issue.last  = (32'(rd_k) == TAPS - 1);
  end

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      decimation <= pdf_pkg::DEC_RESET;
    end else if (cfg_we) begin
      decimation <= cfg_wdata;
    end
  end

  // Per-channel counters and ring pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CHANNELS; i++) begin
        fill_count[i]  <= '0;
        phase_count[i] <= '0;
        wptr[i]        <= '0;
      end
    end else if (accept && smp_ok) begin
      fill_count[ch_idx]  <= fill_next;
      phase_count[ch_idx] <= phase_next;
      wptr[ch_idx]        <= wptr_next;
    end
  end

  // Sample window memory: write on accept, read during the tap walk
  always_ff @(posedge clk) begin
    if (accept && smp_ok) begin
      win_mem[wr_addr] <= sample;
    end
    win_rd <= win_mem[rd_addr];
  end

  // Coefficient memory
  always_ff @(posedge clk) begin
    if (accept && coef_ok) begin
      coef_mem[TAP_W'(coef_index)] <= coef_value;
    end
    coef_rd <= coef_mem[rd_k];
  end

  // Align control with the registered read data
  always_ff @(posedge clk) begin
    if (rst) begin
      issue_q <= '0;
    end else begin
      issue_q <= issue;
    end
  end

  // Sequencer: walk the taps, wait for the sum, hand it to the output
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      rd_k          <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      // Drop the sent beat unless the hold state reloads the register
      if (m_axis_tvalid && m_axis_tready && state != ST_HOLD) begin
        m_axis_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept && smp_ok && emit) begin
            state   <= ST_RUN;
            rd_k    <= '0;
            rd_ch   <= ch_idx;
            rd_base <= wptr_cur;
          end
        end
        ST_RUN: begin
          rd_k <= rd_k + TAP_W'(1);
          if (issue.last) begin
            state <= ST_WAIT;
          end
        end
        ST_WAIT: begin
          if (mac_done) begin
            state <= ST_HOLD;
          end
        end
        ST_HOLD: begin
          if (out_free) begin
            m_axis_tvalid <= 1'b1;
            m_axis_tdata  <= {2'b00, mac_sum};
            m_axis_tuser  <= 2'(rd_ch);
            state         <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  pdf_mac u_mac (
    .clk  (clk),
    .rst  (rst),
    .ctl  (issue_q),
    .smp  (win_rd),
    .coef (coef_rd),
    .done (mac_done),
    .sum  (mac_sum)
  );

`ifndef SYNTHESIS
  a_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    mac_done |-> state == ST_WAIT)
    else $error("MAC finished outside the wait state");

  a_walk_ends: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RUN && issue.last) |=> state == ST_WAIT)
    else $error("tap walk did not end after the last tap");

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    (accept && smp_ok) |-> 32'(fill_count[ch_idx]) <= TAPS)
    else $error("fill count beyond window depth");

  a_phase_bound: assert property (@(posedge clk) disable iff (rst)
    (accept && smp_ok) |-> {1'b0, phase_count[ch_idx]} < pdf_pkg::DEC_MAX)
    else $error("phase count beyond maximum decimation");

  a_out_from_hold: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> $past(state) == ST_HOLD)
    else $error("output beat raised outside the hold state");
`endif

endmodule

/* sim/testbench.sv */
// Self-checking bench for pdm_decimating_fir_core: bursty stream stimulus and stalling sink.
// A class predicts each PCM beat from accepted input beats; depends on pdf_pkg and the core.
`timescale 1ns / 1ps

module testbench;

  localparam int N_CH        = 4;
  localparam int N_TAPS      = 64;
  localparam int TAIL_CYCLES = N_TAPS + 16;
  localparam int HOLD_CYCLES = 400;

  typedef struct packed {
    logic [1:0]                chan;
    logic [pdf_pkg::PCM_W-1:0] pcm;
  } pcm_beat_t;

  // Predicts the filtered PCM beats and holds the ones not yet seen
  class pcm_predictor;
    logic signed [pdf_pkg::COEF_W-1:0]   coef_mem [N_TAPS];
    logic signed [pdf_pkg::SAMPLE_W-1:0] history [N_CH*N_TAPS];
    int unsigned                         fill [N_CH];
    int unsigned                         phase [N_CH];
    logic [pdf_pkg::DEC_W-1:0]           decim;
    pcm_beat_t                           pcm_expected_q [$];
    int unsigned                         n_results;
    int unsigned                         n_errors;

    function new();
      foreach (coef_mem[i]) coef_mem[i] = '0;
      foreach (history[i]) history[i] = '0;
      foreach (fill[i]) begin
        fill[i] = 0;
        phase[i] = 0;
      end
      decim = pdf_pkg::DEC_RESET;
      n_results = 0;
      n_errors = 0;
    endfunction

    function void write_decimation(logic [pdf_pkg::DEC_W-1:0] v);
      decim = v;
    endfunction

    // Zero behaves as one, anything past the maximum saturates
    function int unsigned period();
      if (decim == 0) return 1;
      if (decim > pdf_pkg::DEC_MAX) return pdf_pkg::DEC_MAX;
      return decim;
    endfunction

    function void absorb_beat(logic req, logic [1:0] ch,
                              logic signed [pdf_pkg::SAMPLE_W-1:0] smp,
                              logic [5:0] ci, logic signed [pdf_pkg::COEF_W-1:0] cv);
      int        base;
      longint    acc;
      bit        fire;
      pcm_beat_t e;
      base = ch * N_TAPS;
      acc = 0;
      fire = 0;
      if (req == pdf_pkg::REQ_COEF) begin
        coef_mem[ci] = cv;
        return;
      end
      // Shift the new sample in at the newest position
      for (int k = N_TAPS - 1; k > 0; k--) history[base+k] = history[base+k-1];
      history[base] = smp;
      if (fill[ch] < N_TAPS) begin
        fill[ch]++;
        if (fill[ch] == N_TAPS) begin
          fire = 1;
          phase[ch] = 0;
        end
      end else begin
        phase[ch]++;
        if (phase[ch] >= period()) begin
          fire = 1;
          phase[ch] = 0;
        end
      end
      if (fire) begin
        for (int k = 0; k < N_TAPS; k++)
          acc += longint'(coef_mem[k]) * longint'(history[base+k]);
        e.chan = ch;
        e.pcm = acc[pdf_pkg::PCM_W-1:0];
        pcm_expected_q.push_back(e);
      end
    endfunction

    function void report_error(string msg);
      n_errors++;
      if (n_errors <= 10) $display("%s", msg);
    endfunction

    function void match_pcm(logic [1:0] ch, logic [pdf_pkg::PCM_W-1:0] pcm);
      pcm_beat_t e;
      n_results++;
      if (pcm_expected_q.size() == 0) begin
        report_error($sformatf("unexpected PCM beat: chan %0d value %0d",
                               ch, $signed(pcm)));
      end else begin
        e = pcm_expected_q.pop_front();
        if (e.chan != ch || e.pcm != pcm)
          report_error($sformatf(
            "PCM beat %0d: expected chan %0d value %0d, got chan %0d value %0d",
            n_results, e.chan, $signed(e.pcm), ch, $signed(pcm)));
      end
    endfunction
  endclass

  logic                      clk = 1'b0;
  logic                      rst;
  logic                      cfg_we;
  logic [pdf_pkg::DEC_W-1:0] cfg_wdata;
  logic                      s_axis_tvalid;
  logic                      s_axis_tready;
  logic [39:0]               s_axis_tdata;   // sample[15:0], coef_index[21:16],
                                             // coef_value[37:22], pad
  logic [2:0]                s_axis_tuser;   // req_type[0], channel[2:1]
  logic                      m_axis_tvalid;
  logic                      m_axis_tready;
  logic [39:0]               m_axis_tdata;   // pcm_value[37:0], pad
  logic [1:0]                m_axis_tuser;   // out_channel[1:0]

  pcm_predictor              sb;
  int unsigned               burst_left = 0;
  bit                        no_gaps = 0;
  bit                        long_hold = 0;
  int unsigned               rand_items = 0;
  logic [pdf_pkg::DEC_W-1:0] dec_plan [$] = '{7'd64, 7'd1, 7'd127, 7'd0, 7'd3, 7'd64, 7'd8};

  pdm_decimating_fir_core #(
    .CHANNELS(N_CH),
    .TAPS    (N_TAPS)
  ) uut (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Observe accepted beats and register writes at each edge; a write lands after the edge
  always @(posedge clk) begin
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready)
        sb.match_pcm(m_axis_tuser, m_axis_tdata[pdf_pkg::PCM_W-1:0]);
      if (s_axis_tvalid && s_axis_tready)
        sb.absorb_beat(s_axis_tuser[0], s_axis_tuser[2:1], s_axis_tdata[15:0],
                       s_axis_tdata[21:16], s_axis_tdata[37:22]);
      if (cfg_we)
        sb.write_decimation(cfg_wdata);
    end
  end

  // Sink: switch between stall patterns, hold off for a long stretch on request
  initial begin : sink
    int unsigned rx_left;
    int unsigned rx_mode;
    rx_left = 0;
    rx_mode = 0;
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (long_hold) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        long_hold = 0;
      end
      if (rx_left == 0) begin
        rx_mode = $urandom_range(0, 3);
        rx_left = $urandom_range(16, 96);
      end
      rx_left--;
      case (rx_mode)
        0: m_axis_tready <= 1'b1;
        1: m_axis_tready <= 1'($urandom);
        2: m_axis_tready <= ($urandom_range(0, 3) == 0);
        default: m_axis_tready <= (rx_left % 5 != 0);
      endcase
    end
  end

  // Offer one beat, opening a new burst with a random gap when the last one ran out
  task automatic send_item(input logic req, input logic [1:0] ch, input logic [15:0] smp,
                           input logic [5:0] ci, input logic [15:0] cv);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = no_gaps ? 0 : $urandom_range(0, 6);
      if (gap != 0) begin
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= {8'($urandom), 32'($urandom)};
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {2'b00, cv, ci, smp};
    s_axis_tuser  <= {ch, req};
    do @(posedge clk); while (!s_axis_tready);
  endtask

  // Drop valid, wait out every pending PCM beat, then let the core go quiet
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    while (sb.pcm_expected_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [pdf_pkg::DEC_W-1:0] v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  initial begin : stimulus
    int          phase_no;
    int          hot_ch;
    int unsigned len;
    logic        req;
    logic [1:0]  ch;
    logic [15:0] smp;
    sb = new();
    rst           <= 1'b1;
    cfg_we        <= 1'b0;
    cfg_wdata     <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    cfg_write(pdf_pkg::DEC_RESET);

    // Load the whole coefficient table before any window can fill
    for (int i = 0; i < N_TAPS; i++)
      send_item(pdf_pkg::REQ_COEF, 2'($urandom), 16'($urandom), 6'(i),
                (i == 0) ? 16'h8000 : (i == N_TAPS - 1) ? 16'h7fff : 16'($urandom));

    // Directed: sample extremes on every channel, coefficient rewrites at both ends and two inner taps
    send_item(pdf_pkg::REQ_SAMPLE, 2'd0, 16'h8000, 6'h00, 16'h0000);
    send_item(pdf_pkg::REQ_SAMPLE, 2'd1, 16'h7fff, 6'h3f, 16'hffff);
    send_item(pdf_pkg::REQ_SAMPLE, 2'd2, 16'h0000, 6'h2a, 16'h5555);
    send_item(pdf_pkg::REQ_SAMPLE, 2'd3, 16'hffff, 6'h15, 16'haaaa);
    send_item(pdf_pkg::REQ_COEF,   2'd3, 16'h1234, 6'h3f, 16'h8000);
    send_item(pdf_pkg::REQ_COEF,   2'd0, 16'hffff, 6'h00, 16'h7fff);
    send_item(pdf_pkg::REQ_SAMPLE, 2'd0, 16'h5555, 6'h15, 16'h8000);
    send_item(pdf_pkg::REQ_SAMPLE, 2'd1, 16'haaaa, 6'h2a, 16'h7fff);
    send_item(pdf_pkg::REQ_COEF,   2'd1, 16'h0000, 6'h2a, 16'h5555);
    send_item(pdf_pkg::REQ_COEF,   2'd2, 16'h8000, 6'h15, 16'haaaa);
    send_item(pdf_pkg::REQ_SAMPLE, 2'd2, 16'h0001, 6'h00, 16'h0001);
    send_item(pdf_pkg::REQ_SAMPLE, 2'd3, 16'h8001, 6'h3f, 16'hfffe);
    send_item(pdf_pkg::REQ_COEF,   2'd0, 16'h7fff, 6'h3f, 16'h0000);
    send_item(pdf_pkg::REQ_COEF,   2'd3, 16'h8000, 6'h00, 16'hffff);

    // Random phases, each under its own decimation setting
    phase_no = 0;
    while (rand_items < 800 || sb.n_results < 48) begin
      settle();
      cfg_write(phase_no < dec_plan.size() ? dec_plan[phase_no] : 7'($urandom));
      // Fill channel zero early so the decimation-one phase fires on most samples
      if (phase_no < 2)
        hot_ch = 0;
      else
        hot_ch = $urandom_range(0, 1) ? -1 : $urandom_range(0, N_CH - 1);
      no_gaps = (phase_no % 3 == 1);
      // Every sample on a full window fires at decimation one: stall the sink so the core backs up
      if (phase_no == 1) long_hold = 1;
      len = $urandom_range(80, 140);
      repeat (len) begin
        req = ($urandom_range(0, 99) < 8) ? pdf_pkg::REQ_COEF : pdf_pkg::REQ_SAMPLE;
        ch = (hot_ch >= 0 && $urandom_range(0, 9) < 7) ? 2'(hot_ch) : 2'($urandom);
        case ($urandom_range(0, 9))
          0: smp = 16'h8000;
          1: smp = 16'h7fff;
          default: smp = 16'($urandom);
        endcase
        send_item(req, ch, smp, 6'($urandom), 16'($urandom));
        rand_items++;
      end
      phase_no++;
    end

    settle();
    if (sb.n_errors == 0 && sb.pcm_expected_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Hard stop well past the slowest legal run
  initial begin
    #2400000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
